[rtl/core/oscits_pkg.sv]
// Shared constants and types for the OSC icon-title scanner.
package oscits_pkg;

  localparam int DEF_PAYLOAD_DEPTH = 256;
  localparam int DEF_TITLE_DEPTH   = 256;

  localparam logic [7:0]  BYTE_ESC   = 8'h1B;
  localparam logic [7:0]  BYTE_BEL   = 8'h07;
  localparam logic [7:0]  CHAR_OSC   = 8'h5D;
  localparam logic [7:0]  CHAR_SEMI  = 8'h3B;
  localparam logic [7:0]  CHAR_BSL   = 8'h5C;
  localparam logic [7:0]  CHAR_0     = 8'h30;
  localparam logic [7:0]  CHAR_9     = 8'h39;
  localparam logic [29:0] CMD_LIMIT  = 30'd99999999;
  localparam logic [29:0] CMD_ICON   = 30'd1;
  localparam logic [29:0] CMD_BOTH   = 30'd2;

  localparam logic OP_SCAN = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ESC    = 2'd1,
    MODE_OSC    = 2'd2
  } mode_t;

endpackage

[rtl/core/osc_icon_title_scanner.sv]
// OSC icon-title scanner: byte parser with a two-bank title RAM.
module osc_icon_title_scanner
  import oscits_pkg::*;
#(
  parameter int PAYLOAD_DEPTH = DEF_PAYLOAD_DEPTH,
  parameter int TITLE_DEPTH   = DEF_TITLE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       opcode,
  input  logic [7:0] data_byte,
  input  logic [7:0] read_index,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       title_updated,
  output logic [7:0] title_length,
  output logic [7:0] read_byte,
  output logic [1:0] scan_mode
);

  // One result per transfer, in the cycle after it; a new transfer can be taken
  // every cycle while out_ready is high. Parser state is in flip-flops and
  // updated in the accepting cycle; payload and title bytes share one RAM split
  // into two banks, one write and one registered read per cycle. Committing a
  // title swaps the banks, so no copy is made whatever the title length. No RAM
  // clearing is needed after reset; title bytes beyond title_length read 0.

  localparam int PLW = (PAYLOAD_DEPTH > 2) ? $clog2(PAYLOAD_DEPTH) : 1;
  localparam int TLW = (TITLE_DEPTH > 2) ? $clog2(TITLE_DEPTH) : 1;
  localparam int MAXD = (PAYLOAD_DEPTH > TITLE_DEPTH) ? PAYLOAD_DEPTH : TITLE_DEPTH;
  localparam int AW = (MAXD > 2) ? $clog2(MAXD) : 1;
  localparam int CW0 = (PLW > TLW) ? PLW : TLW;
  localparam int CW = ((CW0 > 8) ? CW0 : 8) + 1;
  localparam logic [CW-1:0] PAY_LIMIT = CW'(PAYLOAD_DEPTH - 1);
  localparam logic [CW-1:0] TITLE_MAX = CW'(TITLE_DEPTH - 1);

  typedef struct packed {
    logic           decided;
    logic           collecting;
    logic [29:0]    number;
    logic           saw_digit;
    logic [PLW-1:0] len;
  } cmd_t;

  typedef struct packed {
    cmd_t st;
    logic wr;
  } feed_t;

  localparam cmd_t CMD_CLEAR = '{decided: 1'b0, collecting: 1'b1, number: '0,
                                 saw_digit: 1'b0, len: '0};

  function automatic feed_t feed(cmd_t s, logic [7:0] b);
    feed_t r;
    r.st = s;
    r.wr = 1'b0;
    if (!s.decided) begin
      if (b >= CHAR_0 && b <= CHAR_9) begin
        if (s.number <= CMD_LIMIT) begin
          r.st.number = (s.number << 3) + (s.number << 1) + {22'd0, b - CHAR_0};
        end
        r.st.saw_digit = 1'b1;
      end else begin
        r.st.decided    = 1'b1;
        r.st.collecting = (b == CHAR_SEMI) && s.saw_digit &&
                          (s.number == CMD_ICON || s.number == CMD_BOTH);
      end
    end else if (s.collecting) begin
      if (CW'(s.len) >= PAY_LIMIT) begin
        r.st.collecting = 1'b0;
        r.st.len        = '0;
      end else begin
        r.wr     = 1'b1;
        r.st.len = s.len + 1'b1;
      end
    end
    return r;
  endfunction

  mode_t          mode, mode_next;
  logic           esc_pend, esc_pend_next;
  cmd_t           cmd, cmd_next;
  logic [TLW-1:0] title_len, title_len_next;
  logic           title_bank;
  logic           commit;
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  logic [7:0]     wr_data;
  feed_t          f1, f2;
  logic           accept, scan, rd_hit;

  logic [TLW-1:0] out_len;
  logic           out_upd, rd_hit_q;
  mode_t          out_mode;
  logic [7:0]     mem_q;
  logic [7:0]     mem [2**(AW+1)];

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign scan     = accept && (opcode == OP_SCAN);
  assign rd_hit   = CW'(read_index) < CW'(title_len);

  always_comb begin
    mode_next      = mode;
    esc_pend_next  = esc_pend;
    cmd_next       = cmd;
    title_len_next = title_len;
    commit         = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = AW'(cmd.len);
    wr_data        = data_byte;
    f1             = feed(cmd, BYTE_ESC);
    f2             = feed(f1.st, data_byte);
    case (mode)
      MODE_NORMAL: begin
        if (data_byte == BYTE_ESC) begin
          mode_next = MODE_ESC;
        end
      end
      MODE_ESC: begin
        if (data_byte == CHAR_OSC) begin
          mode_next     = MODE_OSC;
          cmd_next      = CMD_CLEAR;
          esc_pend_next = 1'b0;
        end else if (data_byte != BYTE_ESC) begin
          mode_next = MODE_NORMAL;
        end
      end
      MODE_OSC: begin
        if ((esc_pend && data_byte == CHAR_BSL) || (!esc_pend && data_byte == BYTE_BEL)) begin
          commit        = cmd.collecting && (cmd.len != '0);
          mode_next     = MODE_NORMAL;
          cmd_next      = CMD_CLEAR;
          esc_pend_next = 1'b0;
          if (CW'(cmd.len) >= TITLE_MAX) begin
            title_len_next = TLW'(TITLE_MAX);
          end else begin
            title_len_next = TLW'(cmd.len);
          end
          if (!commit) begin
            title_len_next = title_len;
          end
        end else if (esc_pend) begin
          // ESC byte already stored when it arrived; store the follower
          esc_pend_next = 1'b0;
          cmd_next      = f2.st;
          wr_en         = f2.wr;
          wr_addr       = AW'(f1.st.len);
        end else if (data_byte == BYTE_ESC) begin
          // provisional store of ESC; length moves only if the follower keeps it
          esc_pend_next = 1'b1;
          wr_en         = f1.wr;
          wr_data       = BYTE_ESC;
        end else begin
          f1      = feed(cmd, data_byte);
          cmd_next = f1.st;
          wr_en   = f1.wr;
        end
      end
      default: begin
        mode_next = MODE_NORMAL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_NORMAL;
      esc_pend   <= 1'b0;
      cmd        <= CMD_CLEAR;
      title_len  <= '0;
      title_bank <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        out_valid <= 1'b1;
      end
      if (scan) begin
        mode      <= mode_next;
        esc_pend  <= esc_pend_next;
        cmd       <= cmd_next;
        title_len <= title_len_next;
        if (commit) begin
          title_bank <= !title_bank;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_upd  <= scan && commit;
      out_len  <= scan ? title_len_next : title_len;
      out_mode <= scan ? mode_next : mode;
      rd_hit_q <= (opcode == OP_READ) && rd_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (scan && wr_en) begin
      mem[{!title_bank, wr_addr}] <= wr_data;
    end
    if (accept && opcode == OP_READ) begin
      mem_q <= mem[{title_bank, AW'(read_index)}];
    end
  end

  assign title_updated = out_upd;
  assign title_length  = 8'(out_len);
  assign read_byte     = rd_hit_q ? mem_q : 8'd0;
  assign scan_mode     = out_mode;

`ifndef NO_ASSERTIONS
  a_pay_len: assert property (@(posedge clk) disable iff (rst)
    cmd.len != '0 |-> cmd.decided && cmd.collecting)
    else $error("payload length held outside collection");
  a_title_bound: assert property (@(posedge clk) disable iff (rst)
    CW'(title_len) <= TITLE_MAX)
    else $error("title length above limit");
  a_upd_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_upd |-> out_len != '0)
    else $error("commit reported with empty title");
  a_esc_osc: assert property (@(posedge clk) disable iff (rst)
    esc_pend |-> mode == MODE_OSC)
    else $error("escape pending outside OSC");
  a_bank_swap: assert property (@(posedge clk) disable iff (rst)
    scan && commit |=> title_bank != $past(title_bank))
    else $error("commit without bank swap");
`endif

endmodule
